// ===== design/rprop_weight_update_top_macros.svh =====
// ----------------------------------------------------------------------------
// Rprop weight update assertion macros
// Shared concurrent assertion forms used by the update engine module.
// ----------------------------------------------------------------------------
`ifndef RPROP_WEIGHT_UPDATE_TOP_MACROS_SVH
`define RPROP_WEIGHT_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RPROP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RPROP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rprop_pkg.sv =====
// ----------------------------------------------------------------------------
// Rprop package
// Widths, register codes, reset values, shared types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rprop_pkg;

	// Entry table size and address width
	localparam int NUM_PARAMS = 1024;
	localparam int ADDR_W     = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

	// Field widths
	localparam int IDX_W  = 10;
	localparam int WGT_W  = 48;
	localparam int GRAD_W = 32;
	localparam int STEP_W = 32;
	localparam int FAC_W  = 16;
	localparam int HALF_W = 24;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_INC_FACTOR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEC_FACTOR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REL_MAX     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP   = 3'd5;

	localparam logic [FAC_W-1:0]  RST_INC_FACTOR = 16'd19661;
	localparam logic [FAC_W-1:0]  RST_DEC_FACTOR = 16'd5407;
	localparam logic [STEP_W-1:0] RST_MAX_STEP   = 32'd838860800;
	localparam logic [STEP_W-1:0] RST_MIN_STEP   = 32'd17;
	localparam logic [STEP_W-1:0] RST_REL_MAX    = 32'd0;
	localparam logic [STEP_W-1:0] RST_INIT_STEP  = 32'd16777216;

	// Sign codes of a gradient and of a stored entry
	localparam logic [1:0] SGN_ZERO = 2'b00;
	localparam logic [1:0] SGN_POS  = 2'b01;
	localparam logic [1:0] SGN_NEG  = 2'b11;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [FAC_W-1:0]  inc_factor;
		logic [FAC_W-1:0]  dec_factor;
		logic [STEP_W-1:0] max_step;
		logic [STEP_W-1:0] min_step;
		logic [STEP_W-1:0] rel_max_step;
		logic [STEP_W-1:0] init_step;
	} cfg_t;

	typedef struct packed {
		logic                    restart;
		logic [ADDR_W-1:0]       addr;
		logic signed [WGT_W-1:0] weight;
		logic [1:0]              gsign;
		logic [STEP_W-1:0]       cap;
	} job_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        sign;
		logic [STEP_W-1:0] step;
	} entry_t;

	// Clamp a wide unsigned value to the step range
	function automatic logic [STEP_W-1:0] sat_step(input logic [63:0] v);
		return (v[63:STEP_W] != '0) ? {STEP_W{1'b1}} : v[STEP_W-1:0];
	endfunction

endpackage

// ===== design/rprop_front.sv =====
// ----------------------------------------------------------------------------
// Rprop front end
// Accepts requests, classifies the gradient sign and computes the step cap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rprop_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rprop_pkg::cfg_t                     cfg,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                item_restart,
	input  logic [rprop_pkg::IDX_W-1:0]         item_index,
	input  logic signed [rprop_pkg::WGT_W-1:0]  item_weight,
	input  logic signed [rprop_pkg::GRAD_W-1:0] item_gradient,
	output logic                                job_valid,
	input  logic                                job_ready,
	output rprop_pkg::job_t                     job
);

	localparam int HW = rprop_pkg::HALF_W;
	localparam int PW = rprop_pkg::STEP_W + HW;

	logic                               in_range;
	logic [1:0]                         gsign_in;
	logic [rprop_pkg::WGT_W-1:0]        absw_in;
	logic                               s1_ready;
	logic                               s2_ready;
	logic [63:0]                        rel_sum;

	logic                               valid_s1;
	logic                               restart_s1;
	logic [rprop_pkg::ADDR_W-1:0]       addr_s1;
	logic signed [rprop_pkg::WGT_W-1:0] weight_s1;
	logic [1:0]                         gsign_s1;
	logic [rprop_pkg::WGT_W-1:0]        absw_s1;

	logic                               valid_s2;
	logic                               restart_s2;
	logic [rprop_pkg::ADDR_W-1:0]       addr_s2;
	logic signed [rprop_pkg::WGT_W-1:0] weight_s2;
	logic [1:0]                         gsign_s2;
	logic [PW-1:0]                      prod_hi_s2;
	logic [PW-1:0]                      prod_lo_s2;

	// Classify the incoming request
	always_comb begin
		in_range = 32'(item_index) < 32'(rprop_pkg::NUM_PARAMS);
		if (item_gradient == '0) begin
			gsign_in = rprop_pkg::SGN_ZERO;
		end else if (item_gradient[rprop_pkg::GRAD_W-1]) begin
			gsign_in = rprop_pkg::SGN_NEG;
		end else begin
			gsign_in = rprop_pkg::SGN_POS;
		end
		absw_in = item_weight[rprop_pkg::WGT_W-1] ? (~item_weight + 48'd1) : item_weight;
	end

	// Handshake through the two stages
	assign s2_ready   = !valid_s2 || job_ready;
	assign s1_ready   = !valid_s1 || s2_ready;
	assign item_ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= item_valid && (item_restart || in_range);
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: register the classified request
	always_ff @(posedge clk) begin
		if (item_valid && s1_ready) begin
			restart_s1 <= item_restart;
			addr_s1    <= rprop_pkg::ADDR_W'(item_index);
			weight_s1  <= item_weight;
			gsign_s1   <= gsign_in;
			absw_s1    <= absw_in;
		end
	end

	// Stage 2: partial products of the relative cap
	always_ff @(posedge clk) begin
		if (valid_s1 && s2_ready) begin
			restart_s2 <= restart_s1;
			addr_s2    <= addr_s1;
			weight_s2  <= weight_s1;
			gsign_s2   <= gsign_s1;
			prod_hi_s2 <= cfg.rel_max_step * absw_s1[2*HW-1:HW];
			prod_lo_s2 <= cfg.rel_max_step * absw_s1[HW-1:0];
		end
	end

	// Sum the partial products and pick the cap
	assign rel_sum = 64'(prod_hi_s2) + 64'(prod_lo_s2[PW-1:HW]);

	always_comb begin
		job.restart = restart_s2;
		job.addr    = addr_s2;
		job.weight  = weight_s2;
		job.gsign   = gsign_s2;
		job.cap     = (cfg.rel_max_step != '0) ? rprop_pkg::sat_step(rel_sum) : cfg.max_step;
	end

	assign job_valid = valid_s2;

endmodule

// ===== design/rprop_fifo.sv =====
// ----------------------------------------------------------------------------
// Rprop job queue
// Short queue that decouples the front end from the update engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rprop_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  rprop_pkg::job_t wr_job,
	output logic            rd_valid,
	input  logic            rd_ready,
	output rprop_pkg::job_t rd_job
);

	localparam int D  = rprop_pkg::QUEUE_DEPTH;
	localparam int PW = rprop_pkg::QPTR_W;

	rprop_pkg::job_t slots_q [D];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	logic            push;
	logic            pop;

	assign wr_ready = count_q != (PW+1)'(D);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_job   = slots_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed requests
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ===== design/rprop_back.sv =====
// ----------------------------------------------------------------------------
// Rprop update engine
// Reads an entry, grows, shrinks or keeps its step, writes it back, moves the weight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rprop_weight_update_top_macros.svh"

module rprop_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rprop_pkg::cfg_t                    cfg,
	input  logic                               job_valid,
	output logic                               job_ready,
	input  rprop_pkg::job_t                    job,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [rprop_pkg::WGT_W-1:0] res_weight,
	output logic [rprop_pkg::STEP_W-1:0]       res_step,
	output logic                               clearing
);

	localparam int AW = rprop_pkg::ADDR_W;
	localparam int SW = rprop_pkg::STEP_W;
	localparam int WW = rprop_pkg::WGT_W;
	localparam int MW = rprop_pkg::STEP_W + rprop_pkg::FAC_W;
	localparam int FRAC_Q14 = 14;

	localparam logic [1:0] MODE_KEEP   = 2'd0;
	localparam logic [1:0] MODE_GROW   = 2'd1;
	localparam logic [1:0] MODE_SHRINK = 2'd2;

	// Entry table and clearing pass
	rprop_pkg::entry_t mem [rprop_pkg::NUM_PARAMS];
	rprop_pkg::entry_t rd_entry_q;
	logic              clearing_q;
	logic [AW-1:0]     clr_cnt_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	rprop_pkg::entry_t mem_wdata;

	// Last write, for reads that miss an in-flight update
	logic              lw_valid_q;
	logic [AW-1:0]     lw_addr_q;
	rprop_pkg::entry_t lw_entry_q;

	logic                 valid_b2;
	logic                 restart_b2;
	logic [AW-1:0]        addr_b2;
	logic signed [WW-1:0] weight_b2;
	logic [1:0]           gsign_b2;
	logic [SW-1:0]        cap_b2;

	logic                 valid_b3;
	logic                 restart_b3;
	logic [AW-1:0]        addr_b3;
	logic signed [WW-1:0] weight_b3;
	logic [1:0]           gsign_b3;
	logic [SW-1:0]        cap_b3;
	logic [1:0]           mode_b3;
	logic [SW-1:0]        step_b3;
	logic [MW-1:0]        prod_b3;

	logic                 valid_b4;
	logic                 restart_b4;
	logic signed [WW-1:0] weight_b4;
	logic [1:0]           gsign_b4;
	logic [SW-1:0]        step_b4;

	logic                 out_valid_q;
	logic signed [WW-1:0] out_weight_q;
	logic [SW-1:0]        out_step_q;

	logic out_free, b4_ready, b3_ready, b3_write, hazard, b2_adv, b2_ready;
	logic pop_update, pop_restart;

	rprop_pkg::entry_t src_entry;
	logic [SW-1:0]     cur_step;
	logic [1:0]        prev_sign;
	logic              grow;
	logic              shrink;
	logic [1:0]        mode_b2;
	logic [MW-1:0]     prod_b2;

	logic [SW-1:0]     scaled_b3;
	logic [SW-1:0]     new_step_b3;
	logic [1:0]        new_sign_b3;

	logic signed [WW+1:0] sum_b4;
	logic signed [WW-1:0] sat_b4;

	// Pipeline handshake
	assign out_free  = !out_valid_q || res_ready;
	assign b4_ready  = !valid_b4 || out_free;
	assign b3_ready  = !valid_b3 || b4_ready;
	assign b3_write  = valid_b3 && !restart_b3 && b4_ready;
	assign hazard    = valid_b2 && valid_b3 && !restart_b2 && !restart_b3 && (addr_b2 == addr_b3);
	assign b2_adv    = valid_b2 && b3_ready && !hazard;
	assign b2_ready  = !valid_b2 || b2_adv;

	// Take a restart only once no update is left in stages 2 and 3
	assign pop_update  = job_valid && !job.restart && !clearing_q && b2_ready;
	assign pop_restart = job_valid && job.restart && !clearing_q && !valid_b2 && !valid_b3;
	assign job_ready   = pop_update || pop_restart;
	assign clearing    = clearing_q;

	// Table write port: clearing pass or write-back
	always_comb begin
		mem_we    = clearing_q || b3_write;
		mem_waddr = clearing_q ? clr_cnt_q : addr_b3;
		if (clearing_q) begin
			mem_wdata = '0;
		end else begin
			mem_wdata.valid = 1'b1;
			mem_wdata.sign  = new_sign_b3;
			mem_wdata.step  = new_step_b3;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (pop_update) begin
			rd_entry_q <= mem[job.addr];
		end
	end

	// Control state: clearing pass, forwarding register, stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			lw_valid_q  <= 1'b0;
			valid_b2    <= 1'b0;
			valid_b3    <= 1'b0;
			valid_b4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_cnt_q == AW'(rprop_pkg::NUM_PARAMS - 1)) begin
					clearing_q <= 1'b0;
					clr_cnt_q  <= '0;
				end else begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
			end else if (pop_restart) begin
				clearing_q <= 1'b1;
				clr_cnt_q  <= '0;
			end
			if (pop_restart) begin
				lw_valid_q <= 1'b0;
			end else if (b3_write) begin
				lw_valid_q <= 1'b1;
			end
			if (b2_ready) begin
				valid_b2 <= pop_update || pop_restart;
			end
			if (b3_ready) begin
				valid_b3 <= b2_adv;
			end
			if (b4_ready) begin
				valid_b4 <= valid_b3;
			end
			if (out_free) begin
				out_valid_q <= valid_b4;
			end
		end
	end

	// Hold the last written entry
	always_ff @(posedge clk) begin
		if (b3_write) begin
			lw_addr_q  <= addr_b3;
			lw_entry_q <= mem_wdata;
		end
	end

	// Stage 2 capture
	always_ff @(posedge clk) begin
		if (b2_ready && job_ready) begin
			restart_b2 <= job.restart;
			addr_b2    <= job.addr;
			weight_b2  <= job.weight;
			gsign_b2   <= job.gsign;
			cap_b2     <= job.cap;
		end
	end

	// Stage 2: pick the entry, decide grow or shrink, scale the step
	always_comb begin
		src_entry = (lw_valid_q && (lw_addr_q == addr_b2)) ? lw_entry_q : rd_entry_q;
		cur_step  = src_entry.valid ? src_entry.step : cfg.init_step;
		prev_sign = src_entry.valid ? src_entry.sign : rprop_pkg::SGN_ZERO;
		grow      = (gsign_b2 != rprop_pkg::SGN_ZERO) && (gsign_b2 == prev_sign);
		shrink    = (gsign_b2 != rprop_pkg::SGN_ZERO) && (prev_sign != rprop_pkg::SGN_ZERO)
			&& !grow;
		if (grow) begin
			mode_b2 = MODE_GROW;
		end else if (shrink) begin
			mode_b2 = MODE_SHRINK;
		end else begin
			mode_b2 = MODE_KEEP;
		end
		prod_b2 = cur_step * (grow ? cfg.inc_factor : cfg.dec_factor);
	end

	always_ff @(posedge clk) begin
		if (b2_adv) begin
			restart_b3 <= restart_b2;
			addr_b3    <= addr_b2;
			weight_b3  <= weight_b2;
			gsign_b3   <= gsign_b2;
			cap_b3     <= cap_b2;
			mode_b3    <= mode_b2;
			step_b3    <= cur_step;
			prod_b3    <= prod_b2;
		end
	end

	// Stage 3: cap or floor the scaled step, update the sign
	always_comb begin
		scaled_b3 = rprop_pkg::sat_step(64'(prod_b3[MW-1:FRAC_Q14]));
		case (mode_b3)
			MODE_GROW: begin
				new_step_b3 = (scaled_b3 < cap_b3) ? scaled_b3 : cap_b3;
				new_sign_b3 = gsign_b3;
			end
			MODE_SHRINK: begin
				new_step_b3 = (scaled_b3 > cfg.min_step) ? scaled_b3 : cfg.min_step;
				new_sign_b3 = rprop_pkg::SGN_ZERO;
			end
			default: begin
				new_step_b3 = step_b3;
				new_sign_b3 = gsign_b3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_b3 && b4_ready) begin
			restart_b4 <= restart_b3;
			weight_b4  <= weight_b3;
			gsign_b4   <= gsign_b3;
			step_b4    <= new_step_b3;
		end
	end

	// Stage 4: move the weight against the gradient, saturate
	always_comb begin
		case (gsign_b4)
			rprop_pkg::SGN_POS: sum_b4 = (WW+2)'(weight_b4) - $signed({18'd0, step_b4});
			rprop_pkg::SGN_NEG: sum_b4 = (WW+2)'(weight_b4) + $signed({18'd0, step_b4});
			default:            sum_b4 = (WW+2)'(weight_b4);
		endcase
		if (sum_b4[WW+1:WW-1] == 3'b000 || sum_b4[WW+1:WW-1] == 3'b111) begin
			sat_b4 = sum_b4[WW-1:0];
		end else if (sum_b4[WW+1]) begin
			sat_b4 = {1'b1, {(WW-1){1'b0}}};
		end else begin
			sat_b4 = {1'b0, {(WW-1){1'b1}}};
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (valid_b4 && out_free) begin
			out_weight_q <= restart_b4 ? '0 : sat_b4;
			out_step_q   <= restart_b4 ? '0 : step_b4;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_weight = out_weight_q;
	assign res_step   = out_step_q;

	`RPROP_ASSERT_IMP(a_no_take_clear, clk, arst_n, clearing_q, !job_ready,
		"request taken during clearing pass")
	`RPROP_ASSERT_IMP(a_one_writer, clk, arst_n, clearing_q, !b3_write,
		"write-back collides with clearing pass")
	`RPROP_ASSERT_NXT(a_restart_clears, clk, arst_n, pop_restart,
		clearing_q && (clr_cnt_q == '0), "restart did not start clearing pass")
	`RPROP_ASSERT_IMP(a_fwd_empty, clk, arst_n, clearing_q, !lw_valid_q,
		"forwarding entry live during clearing pass")

endmodule

// ===== design/rprop_weight_update_top.sv =====
// ----------------------------------------------------------------------------
// Rprop weight update top level
// Streaming per-parameter Rprop step and weight update with config registers.
// ----------------------------------------------------------------------------
// Each update request carries a parameter index, its Q24.24 weight and a
// gradient; one result (new weight, new Q8.24 step) comes back per request.
// Updates are taken at one per clock unless the output stalls or the clearing
// pass runs. Two updates in a row to the same index stall the second, since it
// waits for the first's write-back through the step multiplier and cap select.
// A restart request waits until earlier updates have written back, then clears
// the 1024-entry table, one entry per cycle; the same pass runs after reset.
// No request is accepted during the pass. Configuration writes are always
// accepted and must only be made while the block is idle.
`timescale 1ns / 1ps

module rprop_weight_update_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [95:0]                        s_tdata,   // param_index, weight, gradient, zero pad
	input  logic [0:0]                         s_tuser,   // command
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [79:0]                        m_tdata,   // new_weight, new_step
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rprop_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rprop_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rprop_pkg::cfg_t cfg_q;

	logic            clearing;
	logic            item_ready;
	logic            job_valid_f;
	logic            job_ready_f;
	rprop_pkg::job_t job_f;
	logic            job_valid_b;
	logic            job_ready_b;
	rprop_pkg::job_t job_b;

	logic signed [rprop_pkg::WGT_W-1:0] res_weight;
	logic [rprop_pkg::STEP_W-1:0]       res_step;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inc_factor   <= rprop_pkg::RST_INC_FACTOR;
			cfg_q.dec_factor   <= rprop_pkg::RST_DEC_FACTOR;
			cfg_q.max_step     <= rprop_pkg::RST_MAX_STEP;
			cfg_q.min_step     <= rprop_pkg::RST_MIN_STEP;
			cfg_q.rel_max_step <= rprop_pkg::RST_REL_MAX;
			cfg_q.init_step    <= rprop_pkg::RST_INIT_STEP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rprop_pkg::CFG_INC_FACTOR: cfg_q.inc_factor   <= cfg_data[15:0];
				rprop_pkg::CFG_DEC_FACTOR: cfg_q.dec_factor   <= cfg_data[15:0];
				rprop_pkg::CFG_MAX_STEP:   cfg_q.max_step     <= cfg_data;
				rprop_pkg::CFG_MIN_STEP:   cfg_q.min_step     <= cfg_data;
				rprop_pkg::CFG_REL_MAX:    cfg_q.rel_max_step <= cfg_data;
				rprop_pkg::CFG_INIT_STEP:  cfg_q.init_step    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold off requests during the clearing pass
	assign s_tready = item_ready && !clearing;

	rprop_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item_valid    (s_tvalid && !clearing),
		.item_ready    (item_ready),
		.item_restart  (s_tuser[0]),
		.item_index    (s_tdata[9:0]),
		.item_weight   (s_tdata[57:10]),
		.item_gradient (s_tdata[89:58]),
		.job_valid     (job_valid_f),
		.job_ready     (job_ready_f),
		.job           (job_f)
	);

	rprop_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (job_valid_f),
		.wr_ready (job_ready_f),
		.wr_job   (job_f),
		.rd_valid (job_valid_b),
		.rd_ready (job_ready_b),
		.rd_job   (job_b)
	);

	rprop_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.job_valid  (job_valid_b),
		.job_ready  (job_ready_b),
		.job        (job_b),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_weight (res_weight),
		.res_step   (res_step),
		.clearing   (clearing)
	);

	assign m_tdata = {res_step, res_weight};

endmodule
